### sv/brsr_pkg.sv
// Package for the bridge ADC serial readout unit: phase codes, register
// indexes, result layout and fixed widths. No dependencies.
`default_nettype none

package brsr_pkg;

    localparam int WORD_BITS    = 24;
    localparam int PULSES       = 25;
    localparam int TARE_SAMPLES = 16;

    localparam int HALF_W  = 16;
    localparam int LIMIT_W = 24;
    localparam int NET_W   = 25;
    localparam int BITC_W  = 5;
    localparam int SUM_W   = 31;
    localparam int READS_W = 7;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;
    localparam int ODATA_W = 56;
    localparam int IDATA_W = 8;

    localparam logic [IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OVL_LIMIT   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MEAS_EN     = 2'd2;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 16'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'h800000;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WAIT = 4'b0010,
        PH_LOW  = 4'b0100,
        PH_HIGH = 4'b1000
    } t_phase;

    // Declared highest field first so the lowest bit is the serial clock.
    typedef struct packed {
        logic                   busy_res;
        logic                   tare_done;
        logic                   overload;
        logic [NET_W-1:0]       net_sample;
        logic [WORD_BITS-1:0]   raw_sample;
        logic                   sample_valid;
        logic                   sck;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

### sv/bridge_adc_serial_readout_unit.sv
// Top level of the bridge ADC serial readout unit: stream ports, sequencer
// and output skid stage. Uses brsr_pkg, brsr_seq and brsr_skid.
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid / tready        tdata[0] data_in, tuser[0] cmd
//  m_axis    out  tvalid / tready        tdata: result fields, see port list
//  cfg       in   i_cfg_wr_en            i_cfg_index, i_cfg_wdata
//
// One transaction per cycle in each direction while m_axis_tready is held
// high; each accepted tick yields one registered result (output or skid).
// Sequencer state advances only on an accepted transaction.
// A downstream stall is absorbed by the skid stage; s_axis_tready drops only
// when both output and skid registers hold results.
// Synchronous active-low reset clears all control state and restores register
// defaults.
`default_nettype none

module bridge_adc_serial_readout_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [brsr_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire logic [brsr_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // [0] data_in, [7:1] zero
    input  wire logic [brsr_pkg::IDATA_W-1:0]    s_axis_tdata,
    // [0] cmd
    input  wire logic                            s_axis_tuser,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] sck, [1] sample_valid, [25:2] raw_sample, [50:26] net_sample,
    // [51] overload, [52] tare_done, [53] busy_res, [55:54] zero
    output      logic [brsr_pkg::ODATA_W-1:0]    m_axis_tdata
);
    import brsr_pkg::*;

    logic     accept;
    t_result  seq_result;
    t_result  out_result;

    assign accept = s_axis_tvalid && s_axis_tready;

    brsr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_cmd       (s_axis_tuser),
        .i_data_in   (s_axis_tdata[0]),
        .o_result    (seq_result)
    );

    brsr_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_result (seq_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {(ODATA_W-RESULT_W)'(0), out_result};

endmodule

`default_nettype wire

### sv/brsr_seq.sv
// Readout sequencer: configuration registers, phase state, shift word and
// tare accumulator; produces one result per accepted tick. Uses brsr_pkg.
`default_nettype none

module brsr_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [brsr_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire logic [brsr_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_accept,
    input  wire logic                            i_cmd,
    input  wire logic                            i_data_in,
    output brsr_pkg::t_result                    o_result
);
    import brsr_pkg::*;

    logic [HALF_W-1:0]            r_half;
    logic [LIMIT_W-1:0]           r_limit;
    logic                         r_meas_en;

    t_phase                       r_phase, n_phase;
    logic [HALF_W-1:0]            r_tick, n_tick;
    logic [BITC_W-1:0]            r_bitc, n_bitc;
    logic [WORD_BITS-1:0]         r_shift, n_shift;
    logic [WORD_BITS-1:0]         r_tare, n_tare;
    logic signed [SUM_W-1:0]      r_sum, n_sum;
    logic [READS_W-1:0]           r_reads, n_reads;
    logic                         r_tare_act, n_tare_act;

    logic [HALF_W-1:0]            half_eff;
    logic [HALF_W-1:0]            tick_inc;
    logic                         elapsed;
    logic [BITC_W-1:0]            bitc_inc;
    logic signed [SUM_W-1:0]      sum_base;
    logic signed [SUM_W-1:0]      sum_add;
    logic signed [31:0]           quot;
    logic [WORD_BITS-1:0]         mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= HALF_RESET;
            r_limit   <= LIMIT_RESET;
            r_meas_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half    <= i_cfg_wdata[HALF_W-1:0];
                CFG_OVL_LIMIT:   r_limit   <= i_cfg_wdata[LIMIT_W-1:0];
                CFG_MEAS_EN:     r_meas_en <= i_cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // The word is complete in r_shift on the last pulse: no bit is shifted then.
    assign half_eff = (r_half == '0) ? HALF_W'(1) : r_half;
    assign tick_inc = r_tick + HALF_W'(1);
    assign elapsed  = (tick_inc >= half_eff) || (tick_inc == '0);
    assign bitc_inc = r_bitc + BITC_W'(1);
    assign sum_base = (i_cmd && !r_tare_act) ? '0 : r_sum;
    assign sum_add  = sum_base + {{(SUM_W-WORD_BITS){r_shift[WORD_BITS-1]}}, r_shift};
    assign quot     = 32'(sum_add / TARE_SAMPLES);
    assign mag      = r_shift[WORD_BITS-1] ? (~r_shift + WORD_BITS'(1)) : r_shift;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bitc     = r_bitc;
        n_shift    = r_shift;
        n_tare     = r_tare;
        n_sum      = r_sum;
        n_reads    = r_reads;
        n_tare_act = r_tare_act;
        o_result   = '0;
        o_result.sck = (r_phase != PH_LOW);

        if (i_cmd && !r_tare_act) begin
            n_tare_act = 1'b1;
            n_sum      = '0;
            n_reads    = '0;
        end

        case (r_phase)
            PH_IDLE: begin
                if (!i_data_in && (r_meas_en || n_tare_act)) begin
                    n_phase = PH_WAIT;
                    n_tick  = '0;
                    n_bitc  = '0;
                    n_shift = '0;
                end
            end
            PH_WAIT, PH_LOW: begin
                n_tick = elapsed ? '0 : tick_inc;
                if (elapsed) begin
                    n_phase = (r_phase == PH_WAIT) ? PH_LOW : PH_HIGH;
                end
            end
            PH_HIGH: begin
                n_tick = elapsed ? '0 : tick_inc;
                if (elapsed) begin
                    if (r_bitc < BITC_W'(WORD_BITS)) begin
                        n_shift = {r_shift[WORD_BITS-2:0], i_data_in};
                    end
                    n_bitc = bitc_inc;
                    if (bitc_inc >= BITC_W'(PULSES)) begin
                        n_phase = PH_IDLE;
                        n_bitc  = '0;
                        if (n_tare_act) begin
                            n_sum   = sum_add;
                            n_reads = n_reads + READS_W'(1);
                            if (n_reads >= READS_W'(TARE_SAMPLES)) begin
                                n_tare     = quot[WORD_BITS-1:0];
                                n_tare_act = 1'b0;
                                n_sum      = '0;
                                n_reads    = '0;
                                o_result.tare_done = 1'b1;
                            end
                        end else begin
                            o_result.sample_valid = 1'b1;
                            o_result.raw_sample   = n_shift;
                            o_result.net_sample   = {n_shift[WORD_BITS-1], n_shift}
                                                  - {r_tare[WORD_BITS-1], r_tare};
                            o_result.overload     = (mag > r_limit);
                        end
                    end else begin
                        n_phase = PH_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_result.busy_res = (n_phase != PH_IDLE) || n_tare_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bitc     <= '0;
            r_shift    <= '0;
            r_tare     <= '0;
            r_sum      <= '0;
            r_reads    <= '0;
            r_tare_act <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bitc     <= n_bitc;
            r_shift    <= n_shift;
            r_tare     <= n_tare;
            r_sum      <= n_sum;
            r_reads    <= n_reads;
            r_tare_act <= n_tare_act;
        end
    end

endmodule

`default_nettype wire

### sv/brsr_skid.sv
// Result register with skid stage between the sequencer and the output
// stream. Uses brsr_pkg.
`default_nettype none

module brsr_skid (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output      logic                            o_ready,
    input  wire brsr_pkg::t_result               i_result,
    output      logic                            o_valid,
    input  wire logic                            i_ready,
    output brsr_pkg::t_result                    o_result
);
    import brsr_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_result  r_out;
    t_result  r_skid;
    logic     accept;

    assign o_ready  = !r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (accept) begin
            r_skid <= i_result;
        end
    end

endmodule

`default_nettype wire

### bench/tb_bridge_adc_serial_readout_unit.sv
// Testbench for the bridge ADC serial readout unit: drives converter ticks, shapes reads
// with chosen words, and checks every result against an in-bench sequencer prediction.
// Depends on brsr_pkg and bridge_adc_serial_readout_unit.
`default_nettype none

module tb_bridge_adc_serial_readout_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import brsr_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    class readout_tracker;
        bit [HALF_W-1:0]    half_ticks;
        bit [LIMIT_W-1:0]   ovl_limit;
        bit                 meas_en;
        t_phase             ph;
        bit [HALF_W-1:0]    tick_cnt;
        int unsigned        bit_cnt;
        bit [WORD_BITS-1:0] shreg;
        int                 tare_val;
        int                 tare_acc;
        int unsigned        tare_cnt;
        bit                 taring;
        t_result            pending_readouts[$];
        int unsigned        faults;
        int unsigned        ticks_seen;
        int unsigned        samples;
        int unsigned        overloads;
        int unsigned        tares;

        function new();
            half_ticks = HALF_RESET;
            ovl_limit  = LIMIT_RESET;
            meas_en    = 1'b0;
            ph         = PH_IDLE;
            tick_cnt   = '0;
            bit_cnt    = 0;
            shreg      = '0;
            tare_val   = 0;
            tare_acc   = 0;
            tare_cnt   = 0;
            taring     = 1'b0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_HALF_PERIOD: half_ticks = val[HALF_W-1:0];
                CFG_OVL_LIMIT:   ovl_limit = val[LIMIT_W-1:0];
                CFG_MEAS_EN:     meas_en = val[0];
                default: ;
            endcase
        endfunction

        function bit [HALF_W-1:0] eff_half();
            return (half_ticks == '0) ? HALF_W'(1) : half_ticks;
        endfunction

        function bit phase_over();
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= eff_half() || tick_cnt == '0) begin
                tick_cnt = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Level to put on the data line so that a read picks up the given word.
        function bit planned_din(bit [WORD_BITS-1:0] word);
            bit [HALF_W-1:0] nxt;
            nxt = tick_cnt + 1'b1;
            if (ph == PH_HIGH && bit_cnt < WORD_BITS && (nxt >= eff_half() || nxt == '0))
                return word[WORD_BITS-1-bit_cnt];
            if (ph == PH_IDLE)
                return 1'b0;
            return 1'($urandom_range(0, 1));
        endfunction

        function void take_tick(bit cmd, bit din);
            t_result r;
            int      word;
            int      net_val;
            int      mag;
            r = '0;
            r.sck = (ph != PH_LOW);
            ticks_seen++;
            if (cmd && !taring) begin
                taring   = 1'b1;
                tare_acc = 0;
                tare_cnt = 0;
            end
            case (ph)
                PH_IDLE: begin
                    if (!din && (meas_en || taring)) begin
                        ph       = PH_WAIT;
                        tick_cnt = '0;
                        bit_cnt  = 0;
                        shreg    = '0;
                    end
                end
                PH_WAIT: begin
                    if (phase_over())
                        ph = PH_LOW;
                end
                PH_LOW: begin
                    if (phase_over())
                        ph = PH_HIGH;
                end
                default: begin
                    if (phase_over()) begin
                        if (bit_cnt < WORD_BITS)
                            shreg = {shreg[WORD_BITS-2:0], din};
                        bit_cnt++;
                        if (bit_cnt >= PULSES) begin
                            word    = $signed(shreg);
                            ph      = PH_IDLE;
                            bit_cnt = 0;
                            if (taring) begin
                                tare_acc += word;
                                tare_cnt++;
                                if (tare_cnt >= TARE_SAMPLES) begin
                                    tare_val    = tare_acc / TARE_SAMPLES;
                                    taring      = 1'b0;
                                    tare_acc    = 0;
                                    tare_cnt    = 0;
                                    r.tare_done = 1'b1;
                                    tares++;
                                end
                            end else begin
                                mag            = (word < 0) ? -word : word;
                                net_val        = word - tare_val;
                                r.sample_valid = 1'b1;
                                r.raw_sample   = shreg;
                                r.net_sample   = net_val[NET_W-1:0];
                                r.overload     = (mag > int'(ovl_limit));
                                samples++;
                                if (r.overload)
                                    overloads++;
                            end
                        end else begin
                            ph = PH_LOW;
                        end
                    end
                end
            endcase
            r.busy_res = (ph != PH_IDLE) || taring;
            pending_readouts.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                faults++;
            end
        endfunction

        function void compare_readout(logic [ODATA_W-1:0] data);
            t_result want;
            t_result got;
            if (pending_readouts.size() == 0) begin
                $error("result with none outstanding: %h", data);
                faults++;
                return;
            end
            want = pending_readouts.pop_front();
            got  = data[RESULT_W-1:0];
            check_field("sck", want.sck, got.sck);
            check_field("sample_valid", want.sample_valid, got.sample_valid);
            check_field("raw_sample", want.raw_sample, got.raw_sample);
            check_field("net_sample", want.net_sample, got.net_sample);
            check_field("overload", want.overload, got.overload);
            check_field("tare_done", want.tare_done, got.tare_done);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("pad", '0, data[ODATA_W-1:RESULT_W]);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IDATA_W-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [ODATA_W-1:0]   m_axis_tdata;

    readout_tracker       readouts;
    bit [WORD_BITS-1:0]   cur_word;
    bit                   tx_gaps_on;
    bit                   rx_stall_on;
    int unsigned          stall_left;

    bridge_adc_serial_readout_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 99) < 20) begin
            stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            readouts.compare_readout(m_axis_tdata);
    end

    function automatic bit [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h800000;
            3:       return 24'h7FFFFF;
            4:       return 24'h000001;
            5:       return 24'h800001;
            default: return WORD_BITS'($urandom());
        endcase
    endfunction

    task automatic send_tick(bit cmd, bit din);
        int unsigned gap;
        int unsigned roll;
        gap = 0;
        if (tx_gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 95)
                gap = $urandom_range(8, 40);
            else if (roll >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IDATA_W-1){1'b0}}, din};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        readouts.take_tick(cmd, din);
    endtask

    task automatic run_ticks(int n, int noise_pct);
        bit din;
        repeat (n) begin
            if (readouts.ph == PH_IDLE)
                cur_word = pick_word();
            if ($urandom_range(0, 99) < noise_pct)
                din = 1'($urandom_range(0, 1));
            else
                din = readouts.planned_din(cur_word);
            send_tick(1'b0, din);
        end
    endtask

    task automatic request_tare();
        send_tick(1'b1, readouts.planned_din(cur_word));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (readouts.pending_readouts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        readouts.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        readouts = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: no enable, so ready levels and idle ticks start nothing
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        drain();
        cfg_write(CFG_UNUSED, 24'hFFFFFF);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        drain();
        cfg_write(CFG_HALF_PERIOD, 24'h00FFFF);
        cfg_write(CFG_MEAS_EN, 24'h1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (6) send_tick(1'b0, 1'($urandom_range(0, 1)));
        drain();
        // shorten the half period mid-wait: the wait ends on the next tick
        cfg_write(CFG_HALF_PERIOD, 24'd2);
        run_ticks(4, 0);

        // full rate on both sides, every non-zero magnitude overloads
        drain();
        cfg_write(CFG_HALF_PERIOD, 24'd1);
        cfg_write(CFG_OVL_LIMIT, 24'd0);
        run_ticks(150, 10);

        drain();
        tx_gaps_on = 1'b1;
        rx_stall_on <= 1'b1;
        cfg_write(CFG_HALF_PERIOD, 24'd0);
        cfg_write(CFG_OVL_LIMIT, LIMIT_RESET);
        while (readouts.ph == PH_IDLE)
            run_ticks(1, 0);
        run_ticks(5, 0);
        request_tare();
        run_ticks(150, 10);
        drain();
        cfg_write(CFG_MEAS_EN, 24'h0);
        run_ticks(150, 10);
        request_tare();
        while (readouts.taring)
            run_ticks(20, 10);
        run_ticks(30, 10);

        drain();
        cfg_write(CFG_HALF_PERIOD, 24'd1);
        cfg_write(CFG_OVL_LIMIT, 24'h7FFFFF);
        cfg_write(CFG_MEAS_EN, 24'h1);
        run_ticks(100, 10);

        drain();
        cfg_write(CFG_HALF_PERIOD, 24'd2);
        cfg_write(CFG_OVL_LIMIT, CFG_W'($urandom_range(0, 24'h800000)));
        run_ticks(100, 50);

        // drop the enable with a read under way: that read still completes
        drain();
        cfg_write(CFG_HALF_PERIOD, 24'd1);
        while (readouts.ph == PH_IDLE)
            run_ticks(1, 0);
        run_ticks(10, 0);
        drain();
        cfg_write(CFG_MEAS_EN, 24'h0);
        run_ticks(60, 30);

        drain();
        repeat (4) @(posedge i_clk);
        $display("covered %0d ticks: %0d measurement reads, %0d overloads, %0d tare updates",
                 readouts.ticks_seen, readouts.samples, readouts.overloads, readouts.tares);
        if (readouts.faults == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
